>>> sv/acr_pkg.sv
// shared types, codes and helpers for the aabb collision resolver
`default_nettype none

package acr_pkg;

  // fixed field widths
  localparam int COORD_W = 32;
  localparam int DIM_W = 31;
  localparam int MODE_W = 2;
  localparam int AXIS_W = 2;

  // default and working widths; bounds and depths never exceed WIDE_W signed bits
  localparam int COORD_BITS_DEF = 32;
  localparam int WIDE_W = COORD_W + 4;

  // commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_OBSTACLE = 1'b1;

  // placement modes
  localparam logic [MODE_W-1:0] MODE_CORNER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CENTRED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CAMERA = 2'd2;

  // axis codes
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  // per-axis test result
  typedef struct packed {
    logic                     overlap;
    logic signed [WIDE_W-1:0] depth;
    logic signed [COORD_W-1:0] new_pos;
  } acr_axis_res_t;

  // clamp a wide value into the signed range of pos_w bits, returned sign-extended
  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [WIDE_W-1:0] v,
    input int unsigned pos_w
  );
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    logic signed [WIDE_W-1:0] r;
    hi = $signed((WIDE_W'(1) << (pos_w - 1)) - WIDE_W'(1));
    lo = -hi - WIDE_W'(1);
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[COORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/acr_axis.sv
// one axis of the overlap test, penetration depth and corrected position
`default_nettype none

module acr_axis #(
  parameter int POS_W = 32,
  parameter bit IS_Y = 1'b0
) (
  input  wire logic [acr_pkg::MODE_W-1:0]         mode,
  input  wire logic signed [POS_W-1:0]            pos,
  input  wire logic [acr_pkg::DIM_W-1:0]          dim,
  input  wire logic signed [acr_pkg::COORD_W-1:0] obs_pos,
  input  wire logic [acr_pkg::DIM_W-1:0]          obs_dim,
  output acr_pkg::acr_axis_res_t                  res
);
  import acr_pkg::*;

  logic signed [WIDE_W-1:0] p;
  logic signed [WIDE_W-1:0] d;
  logic signed [WIDE_W-1:0] h;
  logic signed [WIDE_W-1:0] lo1;
  logic signed [WIDE_W-1:0] hi1;
  logic signed [WIDE_W-1:0] lo2;
  logic signed [WIDE_W-1:0] hi2;
  logic signed [WIDE_W-1:0] a;
  logic signed [WIDE_W-1:0] b;
  logic                     push_minus;
  logic signed [WIDE_W-1:0] moved;

  // operands extended to the working width
  assign p = WIDE_W'(pos);
  assign d = $signed(WIDE_W'(dim));
  assign h = $signed(WIDE_W'(dim[DIM_W-1:1]));
  assign lo2 = WIDE_W'(obs_pos);
  assign hi2 = lo2 + $signed(WIDE_W'(obs_dim));

  // moving box bounds by placement mode
  always_comb begin
    case (mode)
      MODE_CAMERA: begin
        if (IS_Y) begin
          lo1 = p - d;
          hi1 = p;
        end else begin
          lo1 = p - h;
          hi1 = p + h;
        end
      end
      MODE_CENTRED: begin
        lo1 = p - h;
        hi1 = p + h;
      end
      default: begin
        lo1 = p;
        hi1 = p + d;
      end
    endcase
  end

  // penetration both ways, keep the smaller
  assign a = hi1 - lo2;
  assign b = hi2 - lo1;
  assign push_minus = (a < b);
  assign moved = push_minus ? (p - a) : (p + b);

  assign res.overlap = (lo1 < hi2) && (hi1 > lo2);
  assign res.depth = push_minus ? a : b;
  assign res.new_pos = sat_coord(moved, POS_W);

endmodule

`default_nettype wire

>>> sv/aabb_collision_resolve.sv
// top level: input register, stored moving box, axis selection and result register
//
// Usage: items enter on the in channel (in_valid/in_ready) with cmd and the box fields.
// cmd 0 loads the moving box (position saturated to COORD_BITS, at most 32, signed bits);
// cmd 1 tests an obstacle box and pushes the stored position out along the axis of
// smallest penetration. Every item gives exactly one result on the out channel
// (out_valid/out_ready): hit, hit_axis and the stored position after the item.
// Path: an accepted item waits in the input register, then its result is written
// into the result register together with the stored box.
// Throughput: one item per cycle unless out_ready stalls; the stored box is updated in
// the same cycle that the next item reads it, so consecutive obstacles chain without gaps.
// Stalls: while out_ready is low a waiting result holds, one more item may sit in the
// input register, and in_ready drops once both are full.
// Reset: clears both registers' valid flags and the stored box to zero position,
// zero extents and corner mode.
`default_nettype none

module aabb_collision_resolve #(
  parameter int COORD_BITS = acr_pkg::COORD_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire logic                                cmd,
  input  wire logic signed [acr_pkg::COORD_W-1:0]  pos_x,
  input  wire logic signed [acr_pkg::COORD_W-1:0]  pos_y,
  input  wire logic signed [acr_pkg::COORD_W-1:0]  pos_z,
  input  wire logic [acr_pkg::DIM_W-1:0]           dim_x,
  input  wire logic [acr_pkg::DIM_W-1:0]           dim_y,
  input  wire logic [acr_pkg::DIM_W-1:0]           dim_z,
  input  wire logic [acr_pkg::MODE_W-1:0]          box_mode,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      logic                                hit,
  output      logic [acr_pkg::AXIS_W-1:0]          hit_axis,
  output      logic signed [acr_pkg::COORD_W-1:0]  out_x,
  output      logic signed [acr_pkg::COORD_W-1:0]  out_y,
  output      logic signed [acr_pkg::COORD_W-1:0]  out_z
);
  import acr_pkg::*;

  localparam int POS_W = (COORD_BITS < 2) ? 2 : ((COORD_BITS < COORD_W) ? COORD_BITS : COORD_W);

  // input register
  logic                      in_full;
  logic                      in_cmd;
  logic signed [COORD_W-1:0] in_pos [3];
  logic [DIM_W-1:0]          in_dim [3];
  logic [MODE_W-1:0]         in_mode;

  // stored moving box
  logic signed [POS_W-1:0]   mover_pos [3];
  logic [DIM_W-1:0]          mover_dim [3];
  logic [MODE_W-1:0]         mover_mode;

  acr_axis_res_t             axis_res [3];
  logic                      advance;
  logic                      overlap_all;
  logic [AXIS_W-1:0]         axis_sel;
  logic signed [COORD_W-1:0] pos_next [3];
  logic                      hit_next;
  logic [AXIS_W-1:0]         axis_next;

  // handshake
  assign advance = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_cmd <= cmd;
      in_pos[0] <= pos_x;
      in_pos[1] <= pos_y;
      in_pos[2] <= pos_z;
      in_dim[0] <= dim_x;
      in_dim[1] <= dim_y;
      in_dim[2] <= dim_z;
      in_mode <= box_mode;
    end
  end

  // per-axis test units
  for (genvar i = 0; i < 3; i++) begin : g_axis
    acr_axis #(
      .POS_W(POS_W),
      .IS_Y (i == 1)
    ) u_axis (
      .mode   (mover_mode),
      .pos    (mover_pos[i]),
      .dim    (mover_dim[i]),
      .obs_pos(in_pos[i]),
      .obs_dim(in_dim[i]),
      .res    (axis_res[i])
    );
  end

  // axis choice: x only when strictly smallest, then y only when strictly below z, else z
  assign overlap_all = axis_res[0].overlap && axis_res[1].overlap && axis_res[2].overlap;

  always_comb begin
    if ((axis_res[0].depth < axis_res[1].depth) && (axis_res[0].depth < axis_res[2].depth)) begin
      axis_sel = AXIS_X;
    end else if (axis_res[1].depth < axis_res[2].depth) begin
      axis_sel = AXIS_Y;
    end else begin
      axis_sel = AXIS_Z;
    end
  end

  // next stored position and result fields
  always_comb begin
    hit_next = 1'b0;
    axis_next = AXIS_X;
    for (int i = 0; i < 3; i++) begin
      pos_next[i] = COORD_W'(mover_pos[i]);
    end
    if (in_cmd == CMD_LOAD) begin
      for (int i = 0; i < 3; i++) begin
        pos_next[i] = sat_coord(WIDE_W'(in_pos[i]), POS_W);
      end
    end else if (overlap_all) begin
      hit_next = 1'b1;
      axis_next = axis_sel;
      for (int i = 0; i < 3; i++) begin
        if (axis_sel == AXIS_W'(i)) begin
          pos_next[i] = axis_res[i].new_pos;
        end
      end
    end
  end

  // stored box update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        mover_pos[i] <= '0;
        mover_dim[i] <= '0;
      end
      mover_mode <= MODE_CORNER;
    end else if (advance) begin
      for (int i = 0; i < 3; i++) begin
        mover_pos[i] <= pos_next[i][POS_W-1:0];
      end
      if (in_cmd == CMD_LOAD) begin
        for (int i = 0; i < 3; i++) begin
          mover_dim[i] <= in_dim[i];
        end
        mover_mode <= in_mode;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit <= hit_next;
      hit_axis <= axis_next;
      out_x <= pos_next[0];
      out_y <= pos_next[1];
      out_z <= pos_next[2];
    end
  end

endmodule

`default_nettype wire

>>> verif/aabb_collision_resolve_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the aabb collision resolver: directed and random box items
module aabb_collision_resolve_tb;
  import acr_pkg::*;

  localparam int POS_W = (COORD_BITS_DEF < 2) ? 2 : ((COORD_BITS_DEF < 32) ? COORD_BITS_DEF : 32);
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_RANDOM = 450;
  localparam int HOLD_CYCLES = 40;
  localparam longint U = 65536;
  localparam longint MAXP = 64'sd2147483647;
  localparam longint MINP = -64'sd2147483648;
  localparam longint MAXD = 64'sd2147483647;

  typedef struct packed {
    logic                    settle;
    logic                    cmd;
    logic [2:0][COORD_W-1:0] pos;
    logic [2:0][DIM_W-1:0]   dim;
    logic [MODE_W-1:0]       mode;
  } box_item_t;

  typedef struct packed {
    logic                    hit;
    logic [AXIS_W-1:0]       axis;
    logic [2:0][COORD_W-1:0] pos;
  } box_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  logic [AXIS_W-1:0] hit_axis;
  logic signed [COORD_W-1:0] out_x, out_y, out_z;
  box_item_t cur = '0;
  box_item_t nxt_item;

  // payload ports follow the item being offered
  logic cmd;
  logic [COORD_W-1:0] pos_x, pos_y, pos_z;
  logic [DIM_W-1:0] dim_x, dim_y, dim_z;
  logic [MODE_W-1:0] box_mode;
  assign cmd = cur.cmd;
  assign pos_x = cur.pos[0];
  assign pos_y = cur.pos[1];
  assign pos_z = cur.pos[2];
  assign dim_x = cur.dim[0];
  assign dim_y = cur.dim[1];
  assign dim_z = cur.dim[2];
  assign box_mode = cur.mode;

  wire [2:0][COORD_W-1:0] got_pos = {out_z, out_y, out_x};
  string pos_name [3] = '{"out_x", "out_y", "out_z"};

  aabb_collision_resolve dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .dim_x     (dim_x),
    .dim_y     (dim_y),
    .dim_z     (dim_z),
    .box_mode  (box_mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .hit_axis  (hit_axis),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // stored moving box as seen by the predictor
  longint mv_pos [3] = '{0, 0, 0};
  logic [DIM_W-1:0] mv_dim [3] = '{0, 0, 0};
  logic [MODE_W-1:0] mv_mode = MODE_CORNER;

  box_item_t item_q [$];
  box_res_t res_q [$];
  box_res_t want;
  int n_directed = 1000000;
  int n_accepted = 0;
  int n_results = 0;
  int n_loads = 0;
  int n_hits = 0;
  int n_axis_hits [3] = '{0, 0, 0};
  int n_err = 0;
  int n_cycles = 0;
  int k;
  logic in_taken = 1'b0;
  int hold_left = 0;
  logic hold_done = 1'b0;

  wire quiet_tx = (n_accepted >= 300) && (n_accepted < 380);
  wire quiet_rx = (n_results >= 300) && (n_results < 380);

  // clamp into the signed position range
  function automatic longint clamp_pos(input longint v);
    longint hi_lim;
    longint lo_lim;
    hi_lim = (longint'(1) << (POS_W - 1)) - 1;
    lo_lim = -hi_lim - 1;
    if (v > hi_lim) return hi_lim;
    if (v < lo_lim) return lo_lim;
    return v;
  endfunction

  // next stored position and hit report for one item
  function automatic box_res_t resolve_box(input box_item_t it);
    longint lo1 [3];
    longint hi1 [3];
    longint lo2 [3];
    longint hi2 [3];
    longint dn [3];
    longint up [3];
    longint m [3];
    longint p, d, h;
    logic over;
    logic [AXIS_W-1:0] ax;
    int i;
    box_res_t r;
    r = '0;
    over = 1'b1;
    if (it.cmd == CMD_LOAD) begin
      for (i = 0; i < 3; i++) begin
        mv_pos[i] = clamp_pos(longint'($signed(it.pos[i])));
        mv_dim[i] = it.dim[i];
      end
      mv_mode = it.mode;
    end else begin
      // moving box bounds by mode, obstacle always corner-anchored
      for (i = 0; i < 3; i++) begin
        p = mv_pos[i];
        d = longint'(mv_dim[i]);
        h = d >>> 1;
        if (mv_mode == MODE_CAMERA && i == 1) begin
          lo1[i] = p - d;
          hi1[i] = p;
        end else if (mv_mode == MODE_CAMERA || mv_mode == MODE_CENTRED) begin
          lo1[i] = p - h;
          hi1[i] = p + h;
        end else begin
          lo1[i] = p;
          hi1[i] = p + d;
        end
        lo2[i] = longint'($signed(it.pos[i]));
        hi2[i] = lo2[i] + longint'(it.dim[i]);
        if (!(lo1[i] < hi2[i] && hi1[i] > lo2[i])) over = 1'b0;
      end
      // push out along the axis of least penetration
      if (over) begin
        for (i = 0; i < 3; i++) begin
          dn[i] = hi1[i] - lo2[i];
          up[i] = hi2[i] - lo1[i];
          m[i] = (dn[i] < up[i]) ? dn[i] : up[i];
        end
        if (m[AXIS_X] < m[AXIS_Y] && m[AXIS_X] < m[AXIS_Z]) begin
          ax = AXIS_X;
        end else if (m[AXIS_Y] < m[AXIS_Z]) begin
          ax = AXIS_Y;
        end else begin
          ax = AXIS_Z;
        end
        if (dn[ax] < up[ax]) begin
          mv_pos[ax] = clamp_pos(mv_pos[ax] - m[ax]);
        end else begin
          mv_pos[ax] = clamp_pos(mv_pos[ax] + m[ax]);
        end
        r.hit = 1'b1;
        r.axis = ax;
      end
    end
    for (i = 0; i < 3; i++) r.pos[i] = COORD_W'(mv_pos[i]);
    return r;
  endfunction

  // queue one item; the first random item and a later one wait for the block to drain
  function automatic void add_item(input logic c, input longint px, input longint py,
                                   input longint pz, input longint dx, input longint dy,
                                   input longint dz, input logic [MODE_W-1:0] md);
    box_item_t it;
    it.settle = (item_q.size() == n_directed) || (item_q.size() == n_directed + 300);
    it.cmd = c;
    it.pos[0] = COORD_W'(px);
    it.pos[1] = COORD_W'(py);
    it.pos[2] = COORD_W'(pz);
    it.dim[0] = DIM_W'(dx);
    it.dim[1] = DIM_W'(dy);
    it.dim[2] = DIM_W'(dz);
    it.mode = md;
    item_q.push_back(it);
  endfunction

  // random coordinate within a few spans of a base
  function automatic longint rand_near(input longint b, input int sh);
    return b + longint'($urandom_range(0, 3 << sh)) - (longint'(2) << sh);
  endfunction

  // sender: next item, or a random gap, at the falling edge after the previous one was taken
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (item_q.size() != 0) nxt_item = item_q[0];
      if (item_q.size() != 0 && !(nxt_item.settle && res_q.size() != 0) &&
          (quiet_tx || $urandom_range(99) >= 12)) begin
        cur <= item_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && n_accepted >= 200) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (!rst) begin
      out_ready <= quiet_rx || ($urandom_range(99) >= 12);
    end
  end

  // monitor: predict on accepted items, compare accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        res_q.push_back(resolve_box(cur));
        if (cur.cmd == CMD_LOAD) n_loads++;
        n_accepted++;
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (res_q.size() == 0) begin
          $error("result with no item pending: hit %0d axis %0d", hit, hit_axis);
          n_err++;
        end else begin
          want = res_q.pop_front();
          n_results++;
          if (want.hit) begin
            n_hits++;
            n_axis_hits[want.axis]++;
          end
          if (hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, hit);
            n_err++;
          end
          if (hit_axis !== want.axis) begin
            $error("hit_axis: expected %0d, got %0d", want.axis, hit_axis);
            n_err++;
          end
          for (k = 0; k < 3; k++) begin
            if (got_pos[k] !== want.pos[k]) begin
              $error("%s: expected %h, got %h", pos_name[k], want.pos[k], got_pos[k]);
              n_err++;
            end
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin : stim
    int sh;
    int nobs;
    longint base [3];
    longint span;

    // obstacle against the reset box, which has zero extent at the origin
    add_item(CMD_OBSTACLE, -5, -5, -5, 10, 10, 10, MODE_CORNER);
    // corner box [0, 10] per axis: touching, then x strictly smallest
    add_item(CMD_LOAD, 0, 0, 0, 10*U, 10*U, 10*U, MODE_CORNER);
    add_item(CMD_OBSTACLE, 10*U, 0, 0, 20*U, 20*U, 20*U, MODE_CORNER);
    add_item(CMD_OBSTACLE, 8*U, 7*U, 6*U, 20*U, 20*U, 20*U, MODE_CORNER);
    // x and y tie
    add_item(CMD_LOAD, 0, 0, 0, 10*U, 10*U, 10*U, MODE_CORNER);
    add_item(CMD_OBSTACLE, 8*U, 8*U, 7*U, 20*U, 20*U, 20*U, MODE_CAMERA);
    // y and z tie
    add_item(CMD_LOAD, 0, 0, 0, 10*U, 10*U, 10*U, MODE_CORNER);
    add_item(CMD_OBSTACLE, 7*U, 8*U, 8*U, 20*U, 20*U, 20*U, MODE_CORNER);
    // identical box: all three tie and both depths equal
    add_item(CMD_LOAD, 0, 0, 0, 10*U, 10*U, 10*U, MODE_CORNER);
    add_item(CMD_OBSTACLE, 0, 0, 0, 10*U, 10*U, 10*U, MODE_CORNER);
    // push toward plus on x
    add_item(CMD_LOAD, 0, 0, 0, 10*U, 10*U, 10*U, MODE_CORNER);
    add_item(CMD_OBSTACLE, -10*U, 5*U, 5*U, 12*U, 20*U, 20*U, MODE_CORNER);
    // centred box with odd extents
    add_item(CMD_LOAD, 0, 0, 0, 10*U+1, 10*U+1, 10*U+1, MODE_CENTRED);
    add_item(CMD_OBSTACLE, 4*U, 3*U, 2*U, 20*U, 20*U, 20*U, MODE_CORNER);
    // camera box, y hangs below the position
    add_item(CMD_LOAD, 0, 10*U, 0, 10*U, 10*U, 10*U, MODE_CAMERA);
    add_item(CMD_OBSTACLE, -20*U, 9*U, -20*U, 60*U, 20*U, 60*U, MODE_CORNER);
    // unused mode acts as corner
    add_item(CMD_LOAD, 0, 0, 0, 10*U, 10*U, 10*U, MODE_SPARE);
    add_item(CMD_OBSTACLE, 8*U, 7*U, 6*U, 20*U, 20*U, 20*U, MODE_CORNER);
    // saturation at the top of the range
    add_item(CMD_LOAD, MAXP-5, 0, 0, 10, 100, 100, MODE_CORNER);
    add_item(CMD_OBSTACLE, MAXP-8, -1000, -1000, 9, 2000, 2000, MODE_CORNER);
    // saturation at the bottom of the range
    add_item(CMD_LOAD, MINP, 0, 0, 20, 100, 100, MODE_CENTRED);
    add_item(CMD_OBSTACLE, MINP, -1000, -1000, 100, 2000, 2000, MODE_CORNER);
    // widest box from the minimum: touching, then a one-lsb overlap
    add_item(CMD_LOAD, MINP, MINP, MINP, MAXD, MAXD, MAXD, MODE_CORNER);
    add_item(CMD_OBSTACLE, -1, -1, -1, MAXD, MAXD, MAXD, MODE_CORNER);
    add_item(CMD_OBSTACLE, -2, -2, -2, MAXD, MAXD, MAXD, MODE_CORNER);
    n_directed = item_q.size();

    // random: mostly a load followed by nearby obstacles, some raw noise
    while (item_q.size() < n_directed + N_RANDOM) begin
      if ($urandom_range(9) == 0) begin
        add_item(1'($urandom_range(1)), longint'($urandom), longint'($urandom),
                 longint'($urandom), longint'($urandom), longint'($urandom),
                 longint'($urandom), MODE_W'($urandom_range(3)));
      end else begin
        sh = $urandom_range(2, 29);
        span = longint'(1) << sh;
        for (k = 0; k < 3; k++) begin
          if ($urandom_range(7) == 0) begin
            base[k] = longint'($signed($urandom));
          end else begin
            base[k] = longint'($urandom_range(0, 4 << sh)) - (longint'(2) << sh);
          end
        end
        add_item(CMD_LOAD, base[0], base[1], base[2],
                 longint'($urandom_range(0, int'(span))),
                 longint'($urandom_range(0, int'(span))),
                 longint'($urandom_range(0, int'(span))), MODE_W'($urandom_range(3)));
        nobs = $urandom_range(1, 6);
        repeat (nobs) begin
          add_item(CMD_OBSTACLE, rand_near(base[0], sh), rand_near(base[1], sh),
                   rand_near(base[2], sh), longint'($urandom_range(0, int'(2*span - 1))),
                   longint'($urandom_range(0, int'(2*span - 1))),
                   longint'($urandom_range(0, int'(2*span - 1))),
                   MODE_W'($urandom_range(3)));
        end
      end
    end

    // reset
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // drain
    while (item_q.size() != 0 || in_valid) @(posedge clk);
    while (res_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("checked %0d results from %0d items: %0d loads, %0d obstacle hits",
             n_results, n_accepted, n_loads, n_hits);
    $display("hits resolved on x %0d, y %0d, z %0d; %0d mismatches",
             n_axis_hits[0], n_axis_hits[1], n_axis_hits[2], n_err);
    if (n_err == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
